FILE: design/pbfa_pkg.sv
`default_nettype none
package pbfa_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned WIDTH_W    = 6;
  localparam int unsigned INDEX_W    = 15;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned POS_W      = 20;
  localparam int unsigned WORD_IDX_W = 15;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned MAX_ADDR_W = 16;
  localparam int unsigned STEP_W     = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(1);

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_t;

  typedef enum logic {
    CFG_FIELD_BITS = 1'b0,
    CFG_ITEM_COUNT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    func_t                 func;
    logic                  err;
    logic [MAX_ADDR_W-1:0] addr0;
    logic [MAX_ADDR_W-1:0] addr1;
    logic [SHIFT_W-1:0]    shift;
    logic [WIDTH_W-1:0]    width;
    logic [DATA_W-1:0]     mask;
    logic [DATA_W-1:0]     value;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD0,
    B_RD1,
    B_LOAD,
    B_EXEC,
    B_WR1,
    B_DONE
  } back_state_t;

endpackage
`default_nettype wire

FILE: design/pbfa_front.sv
`default_nettype none
module pbfa_front #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire pbfa_pkg::cfg_idx_t            cfg_index,
  input  wire logic [pbfa_pkg::COUNT_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire pbfa_pkg::func_t               in_func,
  input  wire logic [pbfa_pkg::INDEX_W-1:0]  in_index,
  input  wire logic [pbfa_pkg::DATA_W-1:0]   in_value,
  output logic                               push,
  input  wire logic                          full,
  output pbfa_pkg::cmd_t                     cmd
);

  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned RW = $clog2(STORE_WORDS) + 1;
  // reciprocal of the store depth, exact for every word index of WORD_IDX_W bits
  localparam int unsigned DIV_SH = pbfa_pkg::WORD_IDX_W + $clog2(STORE_WORDS);
  localparam logic [63:0] RECIP =
    ((64'd1 << DIV_SH) + 64'(STORE_WORDS) - 64'd1) / 64'(STORE_WORDS);
  localparam logic [16:0] RECIP_K = RECIP[16:0];

  logic [pbfa_pkg::WIDTH_W-1:0] field_bits;
  logic [pbfa_pkg::COUNT_W-1:0] item_count;

  pbfa_pkg::front_state_t state, state_next;

  logic [pbfa_pkg::WIDTH_W-1:0]    width_eff;
  logic [pbfa_pkg::DATA_W-1:0]     mask_eff;
  logic [pbfa_pkg::POS_W-1:0]      pos;
  logic [pbfa_pkg::WORD_IDX_W-1:0] word_sh;
  logic [RW-1:0]                   rem;
  logic [RW-1:0]                   rem_inc;
  logic [31:0]                     quot_prod;
  logic [pbfa_pkg::WORD_IDX_W-1:0] quot;
  logic [31:0]                     back_prod;
  logic [pbfa_pkg::WORD_IDX_W-1:0] rem_calc;
  logic [pbfa_pkg::STEP_W-1:0]     step;
  pbfa_pkg::func_t                 func;
  logic                            err;
  logic [pbfa_pkg::SHIFT_W-1:0]    shift;
  logic [pbfa_pkg::WIDTH_W-1:0]    width;
  logic [pbfa_pkg::DATA_W-1:0]     mask;
  logic [pbfa_pkg::DATA_W-1:0]     value;
  logic                            accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_bits <= pbfa_pkg::WIDTH_W'(1);
      item_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pbfa_pkg::CFG_FIELD_BITS: field_bits <= cfg_data[pbfa_pkg::WIDTH_W-1:0];
        pbfa_pkg::CFG_ITEM_COUNT: item_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (field_bits == '0) begin
      width_eff = pbfa_pkg::WIDTH_W'(1);
    end else if (field_bits > pbfa_pkg::WIDTH_W'(32)) begin
      width_eff = pbfa_pkg::WIDTH_W'(32);
    end else begin
      width_eff = field_bits;
    end
    if (width_eff == pbfa_pkg::WIDTH_W'(32)) begin
      mask_eff = '1;
    end else begin
      mask_eff = (pbfa_pkg::DATA_W'(1) << width_eff) - pbfa_pkg::DATA_W'(1);
    end
    pos = pbfa_pkg::POS_W'(in_index) * pbfa_pkg::POS_W'(width_eff);
  end

  assign accept = in_valid && in_ready;

  // word index modulo the store depth: quotient by reciprocal, then remainder
  always_comb begin
    quot_prod = 32'(word_sh) * 32'(RECIP_K);
    back_prod = 32'(quot) * 32'(STORE_WORDS);
    rem_calc  = word_sh - back_prod[pbfa_pkg::WORD_IDX_W-1:0];
    rem_inc   = rem + RW'(1);
    if (rem_inc == RW'(STORE_WORDS)) begin
      rem_inc = '0;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    case (state)
      pbfa_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ({1'b0, in_index} >= item_count) ? pbfa_pkg::F_PUSH : pbfa_pkg::F_MOD;
        end
      end
      pbfa_pkg::F_MOD: begin
        if (step == pbfa_pkg::LAST_STEP) begin
          state_next = pbfa_pkg::F_PUSH;
        end
      end
      pbfa_pkg::F_PUSH: begin
        push = !full;
        if (!full) begin
          state_next = pbfa_pkg::F_IDLE;
        end
      end
      default: state_next = pbfa_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbfa_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func    <= in_func;
      err     <= ({1'b0, in_index} >= item_count);
      shift   <= pos[pbfa_pkg::SHIFT_W-1:0];
      word_sh <= pos[pbfa_pkg::POS_W-1:pbfa_pkg::SHIFT_W];
      width   <= width_eff;
      mask    <= mask_eff;
      value   <= in_value & mask_eff;
      rem     <= '0;
      step    <= '0;
    end else if (state == pbfa_pkg::F_MOD) begin
      if (step == '0) begin
        quot <= pbfa_pkg::WORD_IDX_W'(quot_prod >> DIV_SH);
      end else begin
        rem <= RW'(rem_calc);
      end
      step <= step + pbfa_pkg::STEP_W'(1);
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.func  = func;
    cmd.err   = err;
    cmd.addr0 = pbfa_pkg::MAX_ADDR_W'(AW'(rem));
    cmd.addr1 = pbfa_pkg::MAX_ADDR_W'(AW'(rem_inc));
    cmd.shift = shift;
    cmd.width = width;
    cmd.mask  = mask;
    cmd.value = value;
  end

endmodule
`default_nettype wire

FILE: design/pbfa_queue.sv
`default_nettype none
module pbfa_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire pbfa_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output pbfa_pkg::cmd_t      head
);

  pbfa_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

FILE: design/pbfa_back.sv
`default_nettype none
module pbfa_back #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         empty,
  input  wire pbfa_pkg::cmd_t               head,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [pbfa_pkg::DATA_W-1:0]       out_value,
  output logic                              out_error
);

  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  logic [pbfa_pkg::DATA_W-1:0] mem [STORE_WORDS];
  logic [pbfa_pkg::DATA_W-1:0] rdata;
  logic [AW-1:0]               raddr;
  logic                        rd_en;
  logic [AW-1:0]               waddr;
  logic [pbfa_pkg::DATA_W-1:0] wdata;
  logic                        we;

  pbfa_pkg::back_state_t state, state_next;
  pbfa_pkg::cmd_t        cmd;
  logic [pbfa_pkg::DATA_W-1:0] lo;
  logic [pbfa_pkg::DATA_W-1:0] hi;
  logic [pbfa_pkg::DATA_W-1:0] res_value;
  logic                        res_error;
  logic [63:0]                 cat;
  logic [63:0]                 merged;
  logic [63:0]                 field_mask;
  logic [pbfa_pkg::DATA_W-1:0] extracted;
  logic                        straddle;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    cat        = {hi, lo};
    field_mask = {32'b0, cmd.mask} << cmd.shift;
    merged     = (cat & ~field_mask) | ({32'b0, cmd.value} << cmd.shift);
    extracted  = pbfa_pkg::DATA_W'(cat >> cmd.shift) & cmd.mask;
    straddle   = (7'(cmd.shift) + 7'(cmd.width)) > 7'd32;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    raddr      = cmd.addr0[AW-1:0];
    we         = 1'b0;
    waddr      = cmd.addr0[AW-1:0];
    wdata      = merged[31:0];
    case (state)
      pbfa_pkg::B_IDLE: begin
        pop = !empty;
        if (!empty) begin
          state_next = head.err ? pbfa_pkg::B_DONE : pbfa_pkg::B_RD0;
        end
      end
      pbfa_pkg::B_RD0: begin
        rd_en      = 1'b1;
        state_next = pbfa_pkg::B_RD1;
      end
      pbfa_pkg::B_RD1: begin
        rd_en      = 1'b1;
        raddr      = cmd.addr1[AW-1:0];
        state_next = pbfa_pkg::B_LOAD;
      end
      pbfa_pkg::B_LOAD: state_next = pbfa_pkg::B_EXEC;
      pbfa_pkg::B_EXEC: begin
        if (cmd.func == pbfa_pkg::FUNC_WRITE) begin
          we         = 1'b1;
          state_next = straddle ? pbfa_pkg::B_WR1 : pbfa_pkg::B_DONE;
        end else begin
          state_next = pbfa_pkg::B_DONE;
        end
      end
      pbfa_pkg::B_WR1: begin
        we         = 1'b1;
        waddr      = cmd.addr1[AW-1:0];
        wdata      = merged[63:32];
        state_next = pbfa_pkg::B_DONE;
      end
      pbfa_pkg::B_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = pbfa_pkg::B_IDLE;
        end
      end
      default: state_next = pbfa_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pbfa_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pbfa_pkg::B_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pbfa_pkg::B_IDLE: begin
        if (!empty) begin
          cmd       <= head;
          res_value <= '0;
          res_error <= head.err;
        end
      end
      pbfa_pkg::B_RD1:  lo <= rdata;
      pbfa_pkg::B_LOAD: hi <= rdata;
      pbfa_pkg::B_EXEC: begin
        if (cmd.func == pbfa_pkg::FUNC_READ) begin
          res_value <= extracted;
        end
      end
      pbfa_pkg::B_DONE: begin
        if (!out_valid || out_ready) begin
          out_value <= res_value;
          out_error <= res_error;
        end
      end
      default: ;
    endcase
  end

  a_write_legal: assert property (@(posedge clk) disable iff (rst)
    we |-> (cmd.func == pbfa_pkg::FUNC_WRITE) && !cmd.err)
    else $error("store written for a read or rejected item");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_error) |-> (out_value == '0))
    else $error("rejected item carries a nonzero value");

  a_upper_after_lower: assert property (@(posedge clk) disable iff (rst)
    (state == pbfa_pkg::B_WR1) |-> ($past(state) == pbfa_pkg::B_EXEC))
    else $error("upper word written without lower word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_value))
    else $error("waiting result lost");

endmodule
`default_nettype wire

FILE: design/packed_bit_field_array.sv
// Sequence: the front reduces the word index modulo the store depth and pushes the
//   command into the queue, running ahead of the back; the back reads the lower and
//   upper store words, extracts or merges the field, writes the lower word and, for a
//   straddling write, the upper word, then registers the result.
// Reset: rst synchronous, active high; clears control state and sets field_bits
//   to 1 and item_count to 0. Store contents stay undefined; no clearing pass.
`default_nettype none
module packed_bit_field_array #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // item_index[14:0], write_value[46:15], pad[47]
  input  wire logic        s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // read_value[31:0]
  output logic             m_tuser    // index_error
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  pbfa_pkg::cmd_t front_cmd;
  pbfa_pkg::cmd_t head;

  assign cfg_ready = 1'b1;

  pbfa_front #(.STORE_WORDS(STORE_WORDS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (pbfa_pkg::cfg_idx_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (pbfa_pkg::func_t'(s_tuser)),
    .in_index  (s_tdata[14:0]),
    .in_value  (s_tdata[46:15]),
    .push      (push),
    .full      (full),
    .cmd       (front_cmd)
  );

  pbfa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  pbfa_back #(.STORE_WORDS(STORE_WORDS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (m_tdata),
    .out_error (m_tuser)
  );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned WORDS = 1024;
  localparam int unsigned LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // item_index[14:0], write_value[46:15], pad[47]
  logic        s_tuser;   // func
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // read_value[31:0]
  logic        m_tuser;   // index_error

  packed_bit_field_array DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } reply_t;

  logic [31:0] shadow_words [WORDS];
  logic [31:0] written_bits [WORDS];
  logic [5:0]  width_reg;
  logic [15:0] count_reg;
  reply_t      pending_replies [$];
  int          fail_count;
  int          reply_count;
  int          items_sent;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("packed_bit_field_array: mismatch");
      $finish;
    end
  end

  function automatic int unsigned eff_bits();
    if (width_reg == 0) return 1;
    if (width_reg > 32) return 32;
    return width_reg;
  endfunction

  function automatic logic [31:0] eff_mask();
    int unsigned w;
    w = eff_bits();
    return (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
  endfunction

  // Returns the expected reply and updates the shadow store on writes.
  function automatic reply_t model_access(pbfa_pkg::func_t f, logic [14:0] idx,
                                          logic [31:0] wv);
    reply_t      r;
    int unsigned w;
    logic [31:0] mask;
    int unsigned pos, sh, a0, a1;
    logic [63:0] cat, m64;
    r = '0;
    w = eff_bits();
    mask = eff_mask();
    if (idx >= count_reg) begin
      r.err = 1'b1;
      return r;
    end
    pos = idx * w;
    sh = pos % 32;
    a0 = (pos / 32) % WORDS;
    a1 = (pos / 32 + 1) % WORDS;
    cat = {shadow_words[a1], shadow_words[a0]};
    if (f == pbfa_pkg::FUNC_READ) begin
      r.value = 32'(cat >> sh) & mask;
    end else begin
      m64 = 64'(mask) << sh;
      cat = (cat & ~m64) | (64'(wv & mask) << sh);
      shadow_words[a0] = cat[31:0];
      written_bits[a0] = written_bits[a0] | m64[31:0];
      if (sh + w > 32) begin
        shadow_words[a1] = cat[63:32];
        written_bits[a1] = written_bits[a1] | m64[63:32];
      end
    end
    return r;
  endfunction

  // True when idx is out of range or a read of idx touches only bits already written.
  function automatic bit readable(logic [14:0] idx);
    int unsigned w, pos, sh;
    logic [31:0] mask;
    logic [63:0] have;
    w = eff_bits();
    if (idx >= count_reg) return 1'b1;
    mask = eff_mask();
    pos = idx * w;
    sh = pos % 32;
    have = {written_bits[(pos / 32 + 1) % WORDS], written_bits[(pos / 32) % WORDS]};
    return (32'(have >> sh) & mask) == mask;
  endfunction

  function automatic int gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid stays high after an accept; it drops when a gap or a wait follows.
  task automatic send_item(pbfa_pkg::func_t f, logic [14:0] idx, logic [31:0] wv);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pending_replies.push_back(model_access(f, idx, wv));
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, wv, idx};
    s_tuser <= f;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(pbfa_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pbfa_pkg::CFG_FIELD_BITS) width_reg = val[5:0];
    else count_reg = val;
  endtask

  task automatic set_layout(logic [5:0] bits, logic [15:0] count);
    drain();
    write_reg(pbfa_pkg::CFG_FIELD_BITS, 16'(bits));
    write_reg(pbfa_pkg::CFG_ITEM_COUNT, count);
    cfg_valid <= 1'b0;
  endtask

  // Send a read only where it cannot touch an unwritten bit.
  task automatic try_read(logic [14:0] idx);
    if (readable(idx)) send_item(pbfa_pkg::FUNC_READ, idx, $urandom);
  endtask

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected item value=%h err=%b", $time, m_tdata, m_tuser);
        fail_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (m_tdata !== exp_r.value || m_tuser !== exp_r.err) begin
          $display("%0t: expected value=%h err=%b, actual value=%h err=%b",
                   $time, exp_r.value, exp_r.err, m_tdata, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // Receiver stalls: mostly ready, with short and occasional long holds.
  initial begin
    int hold;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      hold = gap_len();
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic test_directed();
    // Width one, out-of-range with zero count first.
    send_item(pbfa_pkg::FUNC_WRITE, 15'd0, 32'hFFFF_FFFF);
    send_item(pbfa_pkg::FUNC_READ, 15'h7FFF, 32'h0);
    set_layout(6'd32, 16'd32768);
    send_item(pbfa_pkg::FUNC_WRITE, 15'd0, 32'hFFFF_FFFF);
    send_item(pbfa_pkg::FUNC_WRITE, 15'd1, 32'h0);
    send_item(pbfa_pkg::FUNC_WRITE, 15'd1023, 32'hA5A5_5A5A);
    send_item(pbfa_pkg::FUNC_WRITE, 15'd1024, 32'h1234_5678);   // wraps onto word 0
    try_read(15'd0);
    try_read(15'd1023);
    send_item(pbfa_pkg::FUNC_WRITE, 15'h7FFF, 32'h8000_0001);
    try_read(15'h7FFF);
    // Odd width so items straddle word boundaries.
    set_layout(6'd7, 16'd100);
    for (int i = 0; i < 8; i++) begin
      send_item(pbfa_pkg::FUNC_WRITE, 15'(i), 32'hFFFF_FF80 | i);
    end
    try_read(15'd4);
    try_read(15'd5);
    send_item(pbfa_pkg::FUNC_READ, 15'd100, 32'h0);
    send_item(pbfa_pkg::FUNC_WRITE, 15'd100, 32'hFFFF_FFFF);
    // Zero width behaves as one, width above 32 as 32.
    set_layout(6'd0, 16'd64);
    send_item(pbfa_pkg::FUNC_WRITE, 15'd33, 32'h3);
    try_read(15'd33);
    set_layout(6'd63, 16'd8);
    send_item(pbfa_pkg::FUNC_WRITE, 15'd2, 32'hDEAD_BEEF);
    try_read(15'd2);
  endtask

  task automatic test_random();
    logic [14:0] idx;
    int          n;
    for (int phase = 0; phase < 11; phase++) begin
      set_layout(6'($urandom_range(0, 63)),
                 (phase == 3) ? 16'd0 : 16'($urandom_range(1, 32768)));
      for (n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) == 0) idx = 15'($urandom);
        else if (count_reg != 0) idx = 15'($urandom_range(0, count_reg - 1) % 64);
        else idx = 15'($urandom);
        if ($urandom_range(0, 9) == 0) idx = 15'h7FFF - 15'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) send_item(pbfa_pkg::FUNC_WRITE, idx, $urandom);
        else try_read(idx);
        if (phase == 5 && n == 50) drain();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    width_reg = 6'd1;
    count_reg = 16'd0;
    fail_count = 0;
    reply_count = 0;
    items_sent = 0;
    cycle_count = 0;
    foreach (shadow_words[i]) begin
      shadow_words[i] = '0;
      written_bits[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    $display("sent %0d items over widths 0..63 and varied counts, %0d replies checked",
             items_sent, reply_count);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("packed_bit_field_array: match");
    end else begin
      $display("packed_bit_field_array: mismatch");
    end
    $finish;
  end

endmodule
